// ===== rtl/vurd_pkg.sv =====
// ----------------------------------------------------------------------------
// Video update-rate detector package
// Shared types, register indexes and reset values for the detector.
// ----------------------------------------------------------------------------
package vurd_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CNT_W = 4;
  localparam int TIME_W = 32;
  localparam int SIZE_W = 16;
  localparam int WIN_W = 3;
  localparam int WIN_EXT_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DETECTION_ENABLED = 3'd0,
    REG_MIN_UPDATE_WIDTH = 3'd1,
    REG_MIN_UPDATE_HEIGHT = 3'd2,
    REG_RATE_WINDOW_MS = 3'd3,
    REG_NOTIFY_INTERVAL_MS = 3'd4
  } vurd_reg_t;

  localparam logic RST_DETECTION_ENABLED = 1'b1;
  localparam logic [SIZE_W-1:0] RST_MIN_UPDATE_WIDTH = 16'd333;
  localparam logic [SIZE_W-1:0] RST_MIN_UPDATE_HEIGHT = 16'd250;
  localparam logic [SIZE_W-1:0] RST_RATE_WINDOW_MS = 16'd1000;
  localparam logic [SIZE_W-1:0] RST_NOTIFY_INTERVAL_MS = 16'd1000;

  typedef struct packed {
    logic [TIME_W-1:0] time_ms;
    logic check;
    logic window_visible;
    logic on_screen;
    logic fullscreen;
  } vurd_stage_t;

endpackage

// ===== rtl/vurd_ring.sv =====
// ----------------------------------------------------------------------------
// Video update-rate detector timestamp rings
// Keeps the per-window ring pointers and the timestamp memory, records each
// qualifying update and reads back the oldest kept timestamp.
// ----------------------------------------------------------------------------
module vurd_ring #(
  parameter int NUM_WINDOWS = 8,
  parameter int FRAMES = 15
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic kind,
  input  logic [vurd_pkg::WIN_W-1:0] window_index,
  input  logic [vurd_pkg::SIZE_W-1:0] update_width,
  input  logic [vurd_pkg::SIZE_W-1:0] update_height,
  input  logic [vurd_pkg::TIME_W-1:0] time_ms,
  input  logic window_visible,
  input  logic on_screen,
  input  logic fullscreen,
  input  logic detection_enabled,
  input  logic [vurd_pkg::SIZE_W-1:0] min_update_width,
  input  logic [vurd_pkg::SIZE_W-1:0] min_update_height,
  output logic s1_valid,
  output vurd_pkg::vurd_stage_t s1,
  output logic [vurd_pkg::TIME_W-1:0] oldest_stamp,
  input  logic s1_take
);
  import vurd_pkg::*;

  localparam int IDX_W = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;
  localparam int DEPTH = NUM_WINDOWS * FRAMES;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [CNT_W-1:0] ring_start [NUM_WINDOWS];
  logic [CNT_W-1:0] ring_count [NUM_WINDOWS];
  logic [TIME_W-1:0] stamp_ring [DEPTH];

  logic accept;
  logic [WIN_EXT_W-1:0] win_ext;
  logic [IDX_W-1:0] widx;
  logic in_range;
  logic upd;
  logic clear;
  logic ring_full;
  logic [CNT_W-1:0] cur_start;
  logic [CNT_W-1:0] cur_count;
  logic [CNT_W-1:0] start_next;
  logic [CNT_W-1:0] cnt_adj;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W:0] slot_sum;
  logic [CNT_W-1:0] wr_slot;
  logic [ADDR_W-1:0] base_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  assign in_ready = !s1_valid || s1_take;
  assign accept = in_valid && in_ready;

  assign win_ext = WIN_EXT_W'(window_index);
  assign widx = win_ext[IDX_W-1:0];
  assign in_range = win_ext < WIN_EXT_W'(NUM_WINDOWS);
  assign clear = in_range && kind;
  assign upd = in_range && !kind && detection_enabled &&
               (update_width >= min_update_width) &&
               (update_height >= min_update_height);

  assign cur_start = ring_start[widx];
  assign cur_count = ring_count[widx];
  assign ring_full = cur_count >= CNT_W'(FRAMES);

  always_comb begin
    if (ring_full) begin
      start_next = (cur_start == CNT_W'(FRAMES - 1)) ? '0 : cur_start + 1'b1;
      cnt_adj = CNT_W'(FRAMES - 1);
    end else begin
      start_next = cur_start;
      cnt_adj = cur_count;
    end
    count_next = cnt_adj + 1'b1;
    slot_sum = {1'b0, start_next} + {1'b0, cnt_adj};
    if (slot_sum >= (CNT_W + 1)'(FRAMES)) begin
      wr_slot = CNT_W'(slot_sum - (CNT_W + 1)'(FRAMES));
    end else begin
      wr_slot = slot_sum[CNT_W-1:0];
    end
  end

  assign base_addr = ADDR_W'(widx) * ADDR_W'(FRAMES);
  assign wr_addr = base_addr + ADDR_W'(wr_slot);
  assign rd_addr = base_addr + ADDR_W'(start_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WINDOWS; i++) begin
        ring_start[i] <= '0;
        ring_count[i] <= '0;
      end
    end else if (accept) begin
      if (clear) begin
        ring_start[widx] <= '0;
        ring_count[widx] <= '0;
      end else if (upd) begin
        ring_start[widx] <= start_next;
        ring_count[widx] <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && upd) begin
      stamp_ring[wr_addr] <= time_ms;
    end
    if (accept) begin
      oldest_stamp <= stamp_ring[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.time_ms <= time_ms;
      s1.check <= upd && (count_next == CNT_W'(FRAMES));
      s1.window_visible <= window_visible;
      s1.on_screen <= on_screen;
      s1.fullscreen <= fullscreen;
    end
  end

endmodule

// ===== rtl/vurd_notify.sv =====
// ----------------------------------------------------------------------------
// Video update-rate detector decision stage
// Checks the span of the full ring against the rate window, applies the
// notify interval and holds the result item until it is taken.
// ----------------------------------------------------------------------------
module vurd_notify (
  input  logic clk,
  input  logic rst,
  input  logic s1_valid,
  input  vurd_pkg::vurd_stage_t s1,
  input  logic [vurd_pkg::TIME_W-1:0] oldest_stamp,
  output logic s1_take,
  input  logic [vurd_pkg::SIZE_W-1:0] rate_window_ms,
  input  logic [vurd_pkg::SIZE_W-1:0] notify_interval_ms,
  output logic out_valid,
  input  logic out_ready,
  output logic video_rate_met,
  output logic notify,
  output logic notify_fullscreen
);
  import vurd_pkg::*;

  logic [TIME_W-1:0] last_notify_time;
  logic notified_before;
  logic [TIME_W-1:0] span;
  logic [TIME_W-1:0] gap;
  logic met;
  logic note;

  assign s1_take = s1_valid && (!out_valid || out_ready);
  assign span = s1.time_ms - oldest_stamp;
  assign gap = s1.time_ms - last_notify_time;
  assign met = s1.check && (span <= TIME_W'(rate_window_ms));
  assign note = met && (!notified_before || gap >= TIME_W'(notify_interval_ms)) &&
                s1.window_visible && s1.on_screen;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      notified_before <= 1'b0;
      last_notify_time <= '0;
    end else begin
      if (s1_take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (s1_take && note) begin
        notified_before <= 1'b1;
        last_notify_time <= s1.time_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      video_rate_met <= met;
      notify <= note;
      notify_fullscreen <= note && s1.fullscreen;
    end
  end

endmodule

// ===== rtl/video_update_rate_detector_unit.sv =====
// ----------------------------------------------------------------------------
// Video update-rate detector
// Per-window detector of video-rate paint updates with notify throttling.
// ----------------------------------------------------------------------------
// Each input item is registered in the ring stage (s1) and then in the decision
// stage, whose output register holds the result item until it is taken.
// Throughput: one item per cycle while out_ready does not stall the output; the
// timestamp memory has one write and one read port, both used by the same item in its accept cycle.
// Reset clears the ring pointers, the notify history and the output valid and
// loads the register defaults; the timestamp memory is not cleared.
module video_update_rate_detector_unit #(
  parameter int NUM_WINDOWS = 8,
  parameter int FRAMES = 15
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic kind,
  input  logic [vurd_pkg::WIN_W-1:0] window_index,
  input  logic [vurd_pkg::SIZE_W-1:0] update_width,
  input  logic [vurd_pkg::SIZE_W-1:0] update_height,
  input  logic [vurd_pkg::TIME_W-1:0] time_ms,
  input  logic window_visible,
  input  logic on_screen,
  input  logic fullscreen,
  output logic out_valid,
  input  logic out_ready,
  output logic video_rate_met,
  output logic notify,
  output logic notify_fullscreen,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [vurd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vurd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vurd_pkg::*;

  logic detection_enabled;
  logic [SIZE_W-1:0] min_update_width;
  logic [SIZE_W-1:0] min_update_height;
  logic [SIZE_W-1:0] rate_window_ms;
  logic [SIZE_W-1:0] notify_interval_ms;

  logic s1_valid;
  logic s1_take;
  vurd_stage_t s1;
  logic [TIME_W-1:0] oldest_stamp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      detection_enabled <= RST_DETECTION_ENABLED;
      min_update_width <= RST_MIN_UPDATE_WIDTH;
      min_update_height <= RST_MIN_UPDATE_HEIGHT;
      rate_window_ms <= RST_RATE_WINDOW_MS;
      notify_interval_ms <= RST_NOTIFY_INTERVAL_MS;
    end else if (cfg_valid && cfg_ready) begin
      case (vurd_reg_t'(cfg_index))
        REG_DETECTION_ENABLED: detection_enabled <= cfg_data[0];
        REG_MIN_UPDATE_WIDTH: min_update_width <= cfg_data;
        REG_MIN_UPDATE_HEIGHT: min_update_height <= cfg_data;
        REG_RATE_WINDOW_MS: rate_window_ms <= cfg_data;
        REG_NOTIFY_INTERVAL_MS: notify_interval_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  vurd_ring #(
    .NUM_WINDOWS(NUM_WINDOWS),
    .FRAMES(FRAMES)
  ) u_ring (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .window_index(window_index),
    .update_width(update_width),
    .update_height(update_height),
    .time_ms(time_ms),
    .window_visible(window_visible),
    .on_screen(on_screen),
    .fullscreen(fullscreen),
    .detection_enabled(detection_enabled),
    .min_update_width(min_update_width),
    .min_update_height(min_update_height),
    .s1_valid(s1_valid),
    .s1(s1),
    .oldest_stamp(oldest_stamp),
    .s1_take(s1_take)
  );

  vurd_notify u_notify (
    .clk(clk),
    .rst(rst),
    .s1_valid(s1_valid),
    .s1(s1),
    .oldest_stamp(oldest_stamp),
    .s1_take(s1_take),
    .rate_window_ms(rate_window_ms),
    .notify_interval_ms(notify_interval_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .video_rate_met(video_rate_met),
    .notify(notify),
    .notify_fullscreen(notify_fullscreen)
  );

endmodule

// ===== tb/tb_video_update_rate_detector_unit.sv =====
// ----------------------------------------------------------------------------
// Video update-rate detector testbench
// Drives paint-update and window-destroyed events with random handshake gaps,
// predicts the rate, notify and fullscreen flags of each event in a small
// scoreboard, and checks every result item against it across several
// register settings.
// ----------------------------------------------------------------------------
module tb_video_update_rate_detector_unit;
  import vurd_pkg::*;

  localparam int NUM_WIN = 8;
  localparam int FRAMES = 15;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic KIND_PAINT = 1'b0;
  localparam logic KIND_DESTROY = 1'b1;

  typedef struct packed {
    logic met;
    logic note;
    logic note_full;
  } verdict_t;

  class verdict_scoreboard;
    logic [TIME_W-1:0] stamps [NUM_WIN][FRAMES];
    logic [CNT_W-1:0] oldest_slot [NUM_WIN];
    logic [CNT_W-1:0] held [NUM_WIN];
    logic [TIME_W-1:0] last_note_ms;
    bit noted_once;
    logic enabled;
    logic [SIZE_W-1:0] min_w;
    logic [SIZE_W-1:0] min_h;
    logic [SIZE_W-1:0] span_ms;
    logic [SIZE_W-1:0] gap_ms;
    verdict_t expected_verdicts[$];
    int errors;
    int checked;
    int met_seen;
    int notes_seen;

    function new();
      foreach (oldest_slot[i]) begin
        oldest_slot[i] = '0;
        held[i] = '0;
      end
      last_note_ms = '0;
      noted_once = 0;
      enabled = RST_DETECTION_ENABLED;
      min_w = RST_MIN_UPDATE_WIDTH;
      min_h = RST_MIN_UPDATE_HEIGHT;
      span_ms = RST_RATE_WINDOW_MS;
      gap_ms = RST_NOTIFY_INTERVAL_MS;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DETECTION_ENABLED: enabled = data[0];
        REG_MIN_UPDATE_WIDTH: min_w = data;
        REG_MIN_UPDATE_HEIGHT: min_h = data;
        REG_RATE_WINDOW_MS: span_ms = data;
        REG_NOTIFY_INTERVAL_MS: gap_ms = data;
        default: ;
      endcase
    endfunction

    function void note_event(logic kind_v, logic [WIN_W-1:0] win, logic [SIZE_W-1:0] w,
                             logic [SIZE_W-1:0] h, logic [TIME_W-1:0] now, logic vis,
                             logic onscr, logic full);
      verdict_t v;
      int unsigned slot;
      int unsigned cnt;
      logic [TIME_W-1:0] age;
      logic [TIME_W-1:0] since;
      v = '0;
      if (kind_v == KIND_DESTROY) begin
        oldest_slot[win] = '0;
        held[win] = '0;
      end else if (enabled && w >= min_w && h >= min_h) begin
        slot = oldest_slot[win] % FRAMES;
        cnt = held[win];
        if (cnt >= FRAMES) begin
          slot = (slot + 1) % FRAMES;
          cnt = FRAMES - 1;
        end
        stamps[win][(slot + cnt) % FRAMES] = now;
        cnt++;
        oldest_slot[win] = slot[CNT_W-1:0];
        held[win] = cnt[CNT_W-1:0];
        age = now - stamps[win][slot];
        if (cnt == FRAMES && age <= {16'd0, span_ms}) begin
          v.met = 1'b1;
          since = now - last_note_ms;
          if ((!noted_once || since >= {16'd0, gap_ms}) && vis && onscr) begin
            v.note = 1'b1;
            v.note_full = full;
            last_note_ms = now;
            noted_once = 1;
          end
        end
      end
      expected_verdicts.push_back(v);
    endfunction

    function void compare_field(string name, logic want, logic got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %b, actual %b", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_verdict(logic met, logic note, logic note_full);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        $display("%0t: result item with no input pending: met=%b notify=%b fullscreen=%b",
                 $time, met, note, note_full);
        errors++;
        return;
      end
      want = expected_verdicts.pop_front();
      compare_field("video_rate_met", want.met, met);
      compare_field("notify", want.note, note);
      compare_field("notify_fullscreen", want.note_full, note_full);
      checked++;
      if (met === 1'b1) met_seen++;
      if (note === 1'b1) notes_seen++;
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic kind;
  logic [WIN_W-1:0] window_index;
  logic [SIZE_W-1:0] update_width;
  logic [SIZE_W-1:0] update_height;
  logic [TIME_W-1:0] time_ms;
  logic window_visible;
  logic on_screen;
  logic fullscreen;
  logic out_valid;
  logic out_ready;
  logic video_rate_met;
  logic notify;
  logic notify_fullscreen;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  verdict_scoreboard sb = new();
  bit steady = 0;
  int sent = 0;
  int counted = 0;
  int cycles = 0;
  logic [TIME_W-1:0] clock_ms;

  video_update_rate_detector_unit #(
    .NUM_WINDOWS(NUM_WIN),
    .FRAMES(FRAMES)
  ) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        sb.note_event(kind, window_index, update_width, update_height, time_ms,
                      window_visible, on_screen, fullscreen);
      end
      if (out_valid && out_ready) begin
        sb.check_verdict(video_rate_met, notify, notify_fullscreen);
      end
      if (cfg_valid && cfg_ready) begin
        sb.set_register(cfg_index, cfg_data);
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycles);
    $display("tb_video_update_rate_detector_unit: done, errors");
    $finish;
  end

  initial begin : result_sink
    out_ready = 1'b1;
    forever begin
      @(posedge clk);
      if (!steady && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_ready <= 1'b1;
      end
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  task automatic send_event(input logic kind_v, input logic [WIN_W-1:0] win,
                            input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                            input logic [TIME_W-1:0] t, input logic vis,
                            input logic onscr, input logic full);
    if (!steady && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= kind_v;
    window_index <= win;
    update_width <= w;
    update_height <= h;
    time_ms <= t;
    window_visible <= vis;
    on_screen <= onscr;
    fullscreen <= full;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if (kind_v == KIND_DESTROY || (sb.enabled && w >= sb.min_w && h >= sb.min_h)) counted++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_register(input vurd_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_registers(input logic en, input logic [SIZE_W-1:0] w,
                                   input logic [SIZE_W-1:0] h, input logic [SIZE_W-1:0] span,
                                   input logic [SIZE_W-1:0] gap);
    drain();
    repeat (4) @(posedge clk);
    write_register(REG_DETECTION_ENABLED, {15'd0, en});
    write_register(REG_MIN_UPDATE_WIDTH, w);
    write_register(REG_MIN_UPDATE_HEIGHT, h);
    write_register(REG_RATE_WINDOW_MS, span);
    write_register(REG_NOTIFY_INTERVAL_MS, gap);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [SIZE_W-1:0] size_at_least(input logic [SIZE_W-1:0] floor_v);
    return floor_v + SIZE_W'($urandom_range(0, 65535 - floor_v));
  endfunction

  task automatic stray_event();
    logic [SIZE_W-1:0] w;
    case ($urandom_range(0, 3))
      0: send_event(KIND_DESTROY, WIN_W'($urandom_range(0, NUM_WIN - 1)), SIZE_W'($urandom),
                    SIZE_W'($urandom), clock_ms, 1'($urandom), 1'($urandom), 1'($urandom));
      1: begin
        w = (sb.min_w == 0) ? '0 : SIZE_W'($urandom_range(0, sb.min_w - 1));
        send_event(KIND_PAINT, WIN_W'($urandom_range(0, NUM_WIN - 1)), w,
                   size_at_least(sb.min_h), clock_ms, 1'b1, 1'b1, 1'($urandom));
      end
      2: send_event(KIND_PAINT, WIN_W'($urandom_range(0, NUM_WIN - 1)), SIZE_W'($urandom),
                    SIZE_W'($urandom), clock_ms, 1'($urandom), 1'($urandom), 1'($urandom));
      default: send_event(1'($urandom), WIN_W'($urandom), SIZE_W'($urandom), SIZE_W'($urandom),
                          $urandom, 1'($urandom), 1'($urandom), 1'($urandom));
    endcase
  endtask

  // A run is a stream of video-sized updates on one window at a chosen pace,
  // with stray events mixed in.
  task automatic video_run();
    logic [WIN_W-1:0] win;
    logic [TIME_W-1:0] pace;
    int frames;
    win = WIN_W'($urandom_range(0, NUM_WIN - 1));
    frames = $urandom_range(1, 30);
    case ($urandom_range(0, 3))
      0: pace = '0;
      1: pace = sb.span_ms / FRAMES;
      2: pace = 2 * sb.span_ms / FRAMES + 1;
      default: pace = $urandom_range(0, 5000);
    endcase
    repeat (frames) begin
      if ($urandom_range(0, 4) == 0) stray_event();
      clock_ms += $urandom_range(0, pace);
      send_event(KIND_PAINT, win, size_at_least(sb.min_w), size_at_least(sb.min_h), clock_ms,
                 $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0, 1'($urandom));
    end
  endtask

  task automatic run_phase(input int quota, input int cap);
    int start_counted;
    int start_sent;
    start_counted = counted;
    start_sent = sent;
    while (counted - start_counted < quota && sent - start_sent < cap) video_run();
  endtask

  initial begin : stimulus
    logic [TIME_W-1:0] t;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = KIND_PAINT;
    window_index = '0;
    update_width = '0;
    update_height = '0;
    time_ms = '0;
    window_visible = 1'b0;
    on_screen = 1'b0;
    fullscreen = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_DETECTION_ENABLED;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_event(KIND_DESTROY, 3'd7, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
    send_event(KIND_PAINT, 3'd0, RST_MIN_UPDATE_WIDTH - 16'd1, 16'hFFFF, 32'd5, 1'b1, 1'b1, 1'b1);
    send_event(KIND_PAINT, 3'd0, 16'hFFFF, RST_MIN_UPDATE_HEIGHT - 16'd1, 32'd6, 1'b1, 1'b1, 1'b0);
    send_event(KIND_PAINT, 3'd0, 16'd0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0);
    // Fifteen minimum-size updates whose timestamps wrap through zero.
    t = 32'hFFFF_FF00;
    repeat (FRAMES) begin
      t += 32'd20;
      send_event(KIND_PAINT, 3'd3, RST_MIN_UPDATE_WIDTH, RST_MIN_UPDATE_HEIGHT, t,
                 1'b1, 1'b1, 1'b1);
    end
    send_event(KIND_PAINT, 3'd3, 16'hFFFF, 16'hFFFF, t + 32'd20, 1'b1, 1'b1, 1'b0);
    send_event(KIND_PAINT, 3'd3, 16'd400, 16'd300, t + 32'd40, 1'b0, 1'b1, 1'b1);
    send_event(KIND_PAINT, 3'd3, 16'd400, 16'd300, t + 32'd1200, 1'b1, 1'b0, 1'b1);
    send_event(KIND_DESTROY, 3'd3, 16'd0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0);
    send_event(KIND_PAINT, 3'd3, 16'd400, 16'd300, t + 32'd1300, 1'b1, 1'b1, 1'b1);

    clock_ms = $urandom;
    run_phase(180, 1000);
    program_registers(1'b1, 16'd0, 16'd0, 16'hFFFF, 16'd0);
    run_phase(180, 1000);
    program_registers(1'b1, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
    run_phase(180, 1000);
    program_registers(1'b1, SIZE_W'($urandom_range(1, 2000)), SIZE_W'($urandom_range(1, 2000)),
                      SIZE_W'($urandom_range(50, 5000)), SIZE_W'($urandom_range(0, 3000)));
    run_phase(180, 1000);
    program_registers(1'b0, SIZE_W'($urandom_range(0, 500)), SIZE_W'($urandom_range(0, 500)),
                      SIZE_W'($urandom_range(0, 3000)), SIZE_W'($urandom_range(0, 3000)));
    run_phase(20, 100);
    program_registers(1'b1, SIZE_W'($urandom_range(0, 800)), SIZE_W'($urandom_range(0, 800)),
                      SIZE_W'($urandom_range(100, 3000)), SIZE_W'($urandom_range(0, 2000)));
    run_phase(90, 500);
    steady = 1;
    run_phase(90, 500);

    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d items (%0d counted updates or destroys) over six register settings.",
             sent, counted);
    $display("Checked %0d results: %0d met the video rate, %0d raised a notification.",
             sb.checked, sb.met_seen, sb.notes_seen);
    if (sb.errors == 0) begin
      $display("tb_video_update_rate_detector_unit: done, clean");
    end else begin
      $display("tb_video_update_rate_detector_unit: done, errors");
    end
    $finish;
  end
endmodule
